/* design/so3em_pkg.sv */
// so3em_pkg: shared widths, fixed-point constants, types and the cordic arctangent table
// for the so(3) exponential map core. used by so3em_div and so3_exponential_map_core.
// depends on nothing.
`default_nettype none

package so3em_pkg;

   // entry format and matrix geometry
   localparam int FRAC_BITS   = 12;
   localparam int MAT_W       = 16;
   localparam int NUM_ENT     = 9;
   localparam int DATA_W      = NUM_ENT * MAT_W;

   // theta is floor(sqrt(sum of squares / 2)), below 2^17
   localparam int THETA_W     = 17;
   localparam int SQ_W        = 31;
   localparam int PART_W      = 33;
   localparam int HALF_SUM_W  = 33;

   // configuration register
   localparam int              LIMIT_W     = 12;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1;

   // cordic defaults and table depth
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;

   // angle in q.30 after the shift from theta units
   localparam int ANG_SHIFT = 30 - FRAC_BITS;
   localparam int ANG_W     = THETA_W + ANG_SHIFT;
   localparam logic [ANG_W-1:0] TWO_PI_ANG  = 35'd6746518852;
   localparam logic [ANG_W-1:0] FOUR_PI_ANG = 35'd13493037704;
   localparam logic [ANG_W-1:0] EIGHT_PI_ANG = 35'd26986075408;
   localparam logic [ANG_W-1:0] PI_ANG      = 35'd3373259426;

   // cordic datapath (x, y, residual angle), signed q.30
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_KINV = 34'sd652032874;
   localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CW-1:0] TWO_PI_Q30  = 34'sd6746518852;
   localparam logic signed [CW:0]   ONE_Q30_T   = 35'sd1073741824;

   // coefficient dividers
   localparam int D1_QW     = 34;
   localparam int D1_NUM_W  = CW + 1 + FRAC_BITS;
   localparam int A_CLAMP   = 32;
   localparam int T_CLAMP   = 33;
   localparam int A_W       = A_CLAMP + 2;
   localparam int T_W       = T_CLAMP + 2;
   localparam int D2_QW     = 32;
   localparam int D2_NUM_W  = T_W - 1 + FRAC_BITS;
   localparam int B_CLAMP   = 31;
   localparam int B_W       = B_CLAMP + 2;

   // small-angle coefficients in q.30
   localparam logic signed [A_W-1:0] A_SMALL = 34'sd1073741824;
   localparam logic signed [B_W-1:0] B_SMALL = 33'sd536870912;

   // final accumulation
   localparam int PP_W  = 2 * MAT_W;
   localparam int MM_W  = PP_W + 2;
   localparam int AM_W  = A_W + MAT_W;
   localparam int BMM_W = B_W + MM_W;
   localparam int ACC_W = 56;
   localparam logic signed [ACC_W-1:0] DIAG_ONE  = 56'sd1 <<< (30 + FRAC_BITS);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 56'sd536870912;
   localparam logic signed [ACC_W-1:0] OUT_MAX   = 56'sd32767;
   localparam logic signed [ACC_W-1:0] OUT_MIN   = -56'sd32768;

   typedef logic [NUM_ENT-1:0][MAT_W-1:0] mat_type;

   // per-transaction sideband that rides along the whole pipeline
   typedef struct packed {
      mat_type              mat;
      logic                 low_angle;
      logic [THETA_W-1:0]   theta;
      logic                 neg;
   } side_type;

   // arctan(2^-i) in q.30
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:    v = 30'd843314857;
         5'd1:    v = 30'd497837829;
         5'd2:    v = 30'd263043837;
         5'd3:    v = 30'd133525159;
         5'd4:    v = 30'd67021687;
         5'd5:    v = 30'd33543516;
         5'd6:    v = 30'd16775851;
         5'd7:    v = 30'd8388437;
         5'd8:    v = 30'd4194283;
         5'd9:    v = 30'd2097149;
         5'd10:   v = 30'd1048575;
         5'd11:   v = 30'd524287;
         5'd12:   v = 30'd262143;
         5'd13:   v = 30'd131071;
         5'd14:   v = 30'd65535;
         5'd15:   v = 30'd32767;
         5'd16:   v = 30'd16383;
         5'd17:   v = 30'd8191;
         5'd18:   v = 30'd4095;
         5'd19:   v = 30'd2047;
         5'd20:   v = 30'd1023;
         5'd21:   v = 30'd511;
         5'd22:   v = 30'd255;
         5'd23:   v = 30'd127;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* design/so3em_div.sv */
// so3em_div: pipelined restoring divider, one quotient bit per stage, truncating toward
// zero and saturating the quotient magnitude at 2^CLAMP_LOG.
// depends on so3em_pkg.
`default_nettype none

module so3em_div
   import so3em_pkg::*;
#(
   parameter int NUM_W     = D1_NUM_W,
   parameter int QW        = D1_QW,
   parameter int CLAMP_LOG = A_CLAMP
) (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [NUM_W-1:0]          num,
   input  wire logic                      neg,
   input  wire logic [THETA_W-1:0]        den,
   output logic signed [CLAMP_LOG+1:0]    quo
);

   localparam int RW = QW + THETA_W;
   localparam int OW = CLAMP_LOG + 2;
   localparam logic [QW-1:0] CLAMP_MAG = QW'(1) << CLAMP_LOG;

   logic [RW-1:0]      rem_ff [QW];
   logic [QW-1:0]      q_ff   [QW+1];
   logic [THETA_W-1:0] den_ff [QW];
   logic               neg_ff [QW+1];
   logic               ovf_ff [QW+1];
   logic signed [OW-1:0] quo_ff;
   logic signed [OW-1:0] quo_in;
   logic [QW-1:0]      mag;

   // input stage: a quotient too large for QW bits is flagged here and saturates at the output
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num);
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         ovf_ff[0] <= RW'(num) >= {den, {QW{1'b0}}};
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 1; j <= QW; j++) begin : g_bit
      localparam int B = QW - j;
      logic [RW-1:0] dsh;
      logic          fit;
      assign dsh = RW'(den_ff[j-1]) << B;
      assign fit = rem_ff[j-1] >= dsh;

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j]   <= fit ? (q_ff[j-1] | (QW'(1) << B)) : q_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end

      if (j < QW) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= fit ? (rem_ff[j-1] - dsh) : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   // saturate and apply the sign
   always_comb begin
      mag = (ovf_ff[QW] || (q_ff[QW] > CLAMP_MAG)) ? CLAMP_MAG : q_ff[QW];
      quo_in = $signed({1'b0, mag[CLAMP_LOG:0]});
      if (neg_ff[QW]) begin
         quo_in = -quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

/* design/so3_exponential_map_core.sv */
// so3_exponential_map_core: so(3) exponential map by rodrigues' formula, fully pipelined.
// depends on so3em_pkg and so3em_div.
//
// usage:
//   req channel (req_tvalid/req_tready/req_tdata) carries one 3x3 matrix per transaction,
//   nine signed q4.12 entries packed row major, m00 in the lowest 16 bits.
//   rsp channel carries exp(M) in the same packing, each entry rounded and saturated.
//   csr_we/csr_wdata write the small-angle limit (theta at or below it uses A=1, B=1/2);
//   write it only while no transaction is in flight.
// depth: set by the 17-stage square root, the cordic, and two pipelined restoring
//   dividers in a row (34 and 32 quotient stages).
// throughput: one matrix per cycle while the pipeline is not stalled; every stage advances together.
// stall: a result waiting in the output register stalls the whole pipeline only when the
//   last stage is occupied; until then req_tready stays high and the pipeline moves.
// reset: synchronous, active high; clears all valid bits and sets the limit to 1.
`default_nettype none

module so3_exponential_map_core
   import so3em_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [LIMIT_W-1:0]   csr_wdata,   // small_angle_limit
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [DATA_W-1:0]    req_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [DATA_W-1:0]         rsp_tdata    // r00, r01, r02, r10, r11, r12, r20, r21, r22
);

   // stage map
   localparam int ST_ROOT0    = 4;
   localparam int ST_SMALL    = ST_ROOT0 + THETA_W;
   localparam int ST_WRAP     = ST_SMALL + 3;
   localparam int ST_FOLD     = ST_WRAP + 1;
   localparam int ST_CORD_END = ST_FOLD + CORDIC_STAGES;
   localparam int D1_OUT      = ST_CORD_END + 1 + D1_QW + 1;
   localparam int D2_IN       = D1_OUT + 1;
   localparam int D2_OUT      = D2_IN + D2_QW + 1;
   localparam int ST_E1       = D2_OUT + 1;
   localparam int ST_E2       = ST_E1 + 1;
   localparam int ST_E3       = ST_E2 + 1;
   localparam int DEPTH       = ST_E3 + 1;

   logic                 en;
   logic [LIMIT_W-1:0]   limit_ff;
   logic                 vld_ff  [DEPTH];
   side_type             side_ff [DEPTH];
   side_type             side_in [DEPTH];
   logic                 rsp_tvalid_ff;
   logic [DATA_W-1:0]    rsp_tdata_ff;
   logic [DATA_W-1:0]    rsp_tdata_in;

   // pipeline moves unless the last stage is full and the output is held
   assign en         = !vld_ff[DEPTH-1] || !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // ---------------- squares and sum ----------------
   logic [SQ_W-1:0]       sq_ff   [NUM_ENT];
   logic [PART_W-1:0]     part_ff [3];
   logic [HALF_SUM_W-1:0] n_ff;
   logic [PART_W:0]       sum_all;

   for (genvar k = 0; k < NUM_ENT; k++) begin : g_sq
      logic signed [PP_W-1:0] sqp;
      assign sqp = PP_W'($signed(side_ff[0].mat[k])) * PP_W'($signed(side_ff[0].mat[k]));
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k] <= sqp[SQ_W-1:0];
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_part
      always_ff @(posedge clock) begin
         if (en) begin
            part_ff[g] <= PART_W'(sq_ff[3*g]) + PART_W'(sq_ff[3*g+1])
                          + PART_W'(sq_ff[3*g+2]);
         end
      end
   end

   assign sum_all = (PART_W+1)'(part_ff[0]) + (PART_W+1)'(part_ff[1])
                    + (PART_W+1)'(part_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= sum_all[PART_W:1];
      end
   end

   // ---------------- square root, one bit per stage ----------------
   logic [THETA_W-1:0]    root_ff [THETA_W];
   logic [HALF_SUM_W-1:0] nq_ff   [THETA_W];

   for (genvar j = 0; j < THETA_W; j++) begin : g_root
      localparam int B = THETA_W - 1 - j;
      logic [THETA_W-1:0]    prev_root;
      logic [HALF_SUM_W-1:0] prev_n;
      logic [THETA_W-1:0]    cand;
      logic [2*THETA_W-1:0]  cand_sq;

      if (j == 0) begin : g_first
         assign prev_root = '0;
         assign prev_n    = n_ff;
      end else begin : g_next
         assign prev_root = root_ff[j-1];
         assign prev_n    = nq_ff[j-1];
      end

      assign cand    = prev_root | (THETA_W'(1) << B);
      assign cand_sq = (2*THETA_W)'(cand) * (2*THETA_W)'(cand);

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j] <= (cand_sq <= (2*THETA_W)'(prev_n)) ? cand : prev_root;
            nq_ff[j]   <= prev_n;
         end
      end
   end

   // ---------------- angle reduction ----------------
   logic                  small_calc;
   logic [ANG_W-1:0]      ang;
   logic [ANG_W-1:0]      ang_ff [3];
   logic signed [CW-1:0]  pw_ff;
   logic signed [CW-1:0]  z0;
   logic                  fold_neg;

   assign small_calc = !(root_ff[THETA_W-1] > THETA_W'(limit_ff));
   assign ang        = {root_ff[THETA_W-1], {ANG_SHIFT{1'b0}}};

   // modulo two pi by three conditional subtracts
   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff[0] <= (ang >= EIGHT_PI_ANG) ? ang - EIGHT_PI_ANG : ang;
         ang_ff[1] <= (ang_ff[0] >= FOUR_PI_ANG) ? ang_ff[0] - FOUR_PI_ANG : ang_ff[0];
         ang_ff[2] <= (ang_ff[1] >= TWO_PI_ANG) ? ang_ff[1] - TWO_PI_ANG : ang_ff[1];
      end
   end

   // wrap into (-pi, pi]
   always_ff @(posedge clock) begin
      if (en) begin
         pw_ff <= (ang_ff[2] > PI_ANG) ? $signed(CW'(ang_ff[2])) - TWO_PI_Q30
                                       : $signed(CW'(ang_ff[2]));
      end
   end

   // fold into [-pi/2, pi/2], cos changes sign
   always_comb begin
      z0       = pw_ff;
      fold_neg = 1'b0;
      if (pw_ff > HALF_PI_Q30) begin
         z0       = PI_Q30 - pw_ff;
         fold_neg = 1'b1;
      end else if (pw_ff < -HALF_PI_Q30) begin
         z0       = -PI_Q30 - pw_ff;
         fold_neg = 1'b1;
      end
   end

   // ---------------- cordic rotation ----------------
   logic signed [CW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] z_ff [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_KINV;
         y_ff[0] <= '0;
         z_ff[0] <= z0;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      logic signed [CW-1:0] at;
      assign at = $signed(CW'(atan_q30(5'(i))));
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   // ---------------- coefficient division ----------------
   logic signed [CW-1:0]   s_val;
   logic signed [CW-1:0]   c_val;
   logic signed [CW:0]     t_num;
   logic [CW-1:0]          s_mag;
   logic [CW:0]            t_mag;
   logic signed [A_W-1:0]  a_quo;
   logic signed [T_W-1:0]  t_quo;
   logic [T_W-1:0]         t2_mag;
   logic signed [B_W-1:0]  b_quo;
   logic signed [A_W-1:0]  a_ff [D2_QW+2];

   assign s_val  = y_ff[CORDIC_STAGES];
   assign c_val  = side_ff[ST_CORD_END].neg ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
   assign t_num  = ONE_Q30_T - (CW+1)'(c_val);
   assign s_mag  = (s_val < 0) ? CW'(-s_val) : CW'(s_val);
   assign t_mag  = (t_num < 0) ? (CW+1)'(-t_num) : (CW+1)'(t_num);

   so3em_div #(
      .NUM_W     (D1_NUM_W),
      .QW        (D1_QW),
      .CLAMP_LOG (A_CLAMP)
   ) u_div_a (
      .clock (clock),
      .en    (en),
      .num   ({1'b0, s_mag, {FRAC_BITS{1'b0}}}),
      .neg   (s_val < 0),
      .den   (side_ff[ST_CORD_END].theta),
      .quo   (a_quo)
   );

   so3em_div #(
      .NUM_W     (D1_NUM_W),
      .QW        (D1_QW),
      .CLAMP_LOG (T_CLAMP)
   ) u_div_t (
      .clock (clock),
      .en    (en),
      .num   ({t_mag, {FRAC_BITS{1'b0}}}),
      .neg   (t_num < 0),
      .den   (side_ff[ST_CORD_END].theta),
      .quo   (t_quo)
   );

   assign t2_mag = (t_quo < 0) ? T_W'(-t_quo) : T_W'(t_quo);

   so3em_div #(
      .NUM_W     (D2_NUM_W),
      .QW        (D2_QW),
      .CLAMP_LOG (B_CLAMP)
   ) u_div_b (
      .clock (clock),
      .en    (en),
      .num   ({t2_mag[T_W-2:0], {FRAC_BITS{1'b0}}}),
      .neg   (t_quo < 0),
      .den   (side_ff[D1_OUT].theta),
      .quo   (b_quo)
   );

   // A waits alongside the second division
   for (genvar j = 0; j < D2_QW + 2; j++) begin : g_adly
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[j] <= (j == 0) ? a_quo : a_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // ---------------- I + A*M + B*M*M ----------------
   logic signed [A_W-1:0]   a1_ff, a2_ff;
   logic signed [B_W-1:0]   b1_ff, b2_ff;
   logic signed [PP_W-1:0]  pp_ff  [NUM_ENT*3];
   logic signed [MM_W-1:0]  mm_ff  [NUM_ENT];
   logic signed [AM_W-1:0]  am_ff  [NUM_ENT];
   logic signed [BMM_W-1:0] bmm_ff [NUM_ENT];

   // coefficient select
   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= side_ff[D2_OUT].low_angle ? A_SMALL : a_ff[D2_QW+1];
         b1_ff <= side_ff[D2_OUT].low_angle ? B_SMALL : b_quo;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         localparam int E = r * 3 + c;
         logic signed [ACC_W-1:0] acc;
         logic signed [ACC_W-1:0] rnd;
         logic [MAT_W-1:0]        v;

         // partial products of M*M
         for (genvar k = 0; k < 3; k++) begin : g_pp
            always_ff @(posedge clock) begin
               if (en) begin
                  pp_ff[E*3+k] <= PP_W'($signed(side_ff[D2_OUT].mat[r*3+k]))
                                  * PP_W'($signed(side_ff[D2_OUT].mat[k*3+c]));
               end
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               mm_ff[E]  <= MM_W'(pp_ff[E*3]) + MM_W'(pp_ff[E*3+1]) + MM_W'(pp_ff[E*3+2]);
               am_ff[E]  <= AM_W'(a2_ff) * AM_W'($signed(side_ff[ST_E2].mat[E]));
               bmm_ff[E] <= BMM_W'(b2_ff) * BMM_W'(mm_ff[E]);
            end
         end

         // accumulate, round to nearest, saturate
         always_comb begin
            acc = ACC_W'(am_ff[E]) + ACC_W'(bmm_ff[E] >>> FRAC_BITS);
            if (r == c) begin
               acc = acc + DIAG_ONE;
            end
            rnd = (acc + ROUND_HALF) >>> 30;
            if (rnd > OUT_MAX) begin
               v = OUT_MAX[MAT_W-1:0];
            end else if (rnd < OUT_MIN) begin
               v = OUT_MIN[MAT_W-1:0];
            end else begin
               v = rnd[MAT_W-1:0];
            end
         end

         assign rsp_tdata_in[E*MAT_W +: MAT_W] = v;
      end
   end

   // ---------------- valid and sideband line ----------------
   always_comb begin
      side_in[0].mat       = req_tdata;
      side_in[0].low_angle = 1'b0;
      side_in[0].theta     = '0;
      side_in[0].neg       = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in[0];
      end
   end

   for (genvar k = 1; k < DEPTH; k++) begin : g_line
      always_comb begin
         side_in[k] = side_ff[k-1];
         if (k == ST_SMALL) begin
            side_in[k].low_angle = small_calc;
            side_in[k].theta     = root_ff[THETA_W-1];
         end
         if (k == ST_FOLD) begin
            side_in[k].neg = fold_neg;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tvalid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire
